// ===== rtl/core/dpr_pkg.sv =====
package dpr_pkg;

  // Vector length, word and index widths, and the widths that follow from them.
  localparam int VEC_LEN  = 8;
  localparam int WORD_W   = 32;
  localparam int ACC_W    = 2 * WORD_W;
  localparam int IDX_W    = 5;
  localparam int ELEM_AW  = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;

  // Register map.
  localparam logic [IDX_W-1:0] IDX_B_BASE = IDX_W'(VEC_LEN);
  localparam logic [IDX_W-1:0] IDX_START  = IDX_W'(2 * VEC_LEN);
  localparam logic [IDX_W-1:0] IDX_DONE   = IDX_W'(2 * VEC_LEN + 1);
  localparam logic [IDX_W-1:0] IDX_LOW    = IDX_W'(2 * VEC_LEN + 2);
  localparam logic [IDX_W-1:0] IDX_HIGH   = IDX_W'(2 * VEC_LEN + 3);

  // Last element address issued by the sequencer.
  localparam logic [ELEM_AW-1:0] ELEM_LAST = ELEM_AW'(VEC_LEN - 1);

  // Access kinds.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_RUN,
    ST_DRAIN,
    ST_RESP
  } state_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctl_t;

  // Status back from the multiply-accumulate unit.
  typedef struct packed {
    logic pend;
  } mac_sts_t;

endpackage

// ===== rtl/core/dpr_ram.sv =====
module dpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/dpr_mac.sv =====
module dpr_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dpr_pkg::mac_ctl_t             ctl,
  input  logic [dpr_pkg::WORD_W-1:0]    op_a,
  input  logic [dpr_pkg::WORD_W-1:0]    op_b,
  output dpr_pkg::mac_sts_t             sts,
  output logic [dpr_pkg::ACC_W-1:0]     acc
);
  import dpr_pkg::*;

  logic signed [WORD_W-1:0] sa;
  logic signed [WORD_W-1:0] sb;
  logic signed [ACC_W-1:0]  prod_nxt;
  logic signed [ACC_W-1:0]  prod_r;
  logic                     prod_vld_r;
  logic [ACC_W-1:0]         acc_r;
  logic [ACC_W-1:0]         acc_nxt;

  // Signed 32 by 32 product, registered before the accumulator.
  assign sa       = op_a;
  assign sb       = op_b;
  assign prod_nxt = sa * sb;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= prod_nxt;
    end
  end

  // The accumulator wraps modulo two to the sixty-fourth.
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (prod_vld_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      acc_r      <= '0;
    end else begin
      prod_vld_r <= ctl.en;
      acc_r      <= acc_nxt;
    end
  end

  assign sts.pend = prod_vld_r;
  assign acc      = acc_r;

endmodule

// ===== rtl/core/dot_product_register_device.sv =====
// A beat is accepted when start is high and busy is low. Its result is marked by out_valid
// in state RESP, which most accesses reach straight from IDLE, a vector element read through
// READ and a start through RUN, which feeds one element per cycle to a shared multiplier and
// accumulator, and then DRAIN. A new beat waits for the last result, as busy stays high in RESP.
// Reset: synchronous, active low; clears accumulator, done and sequencer, then busy stays high for
// a pass that writes zero to every vector element. Results cannot stall.
module dot_product_register_device (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [dpr_pkg::IDX_W-1:0]     in_reg_index,
  input  logic [dpr_pkg::WORD_W-1:0]    in_write_data,
  output logic                          out_valid,
  output logic [dpr_pkg::WORD_W-1:0]    out_read_data,
  output logic                          out_bad_index
);
  import dpr_pkg::*;

  state_t               state_r;
  state_t               state_nxt;
  logic [ELEM_AW-1:0]   cnt_r;
  logic [ELEM_AW-1:0]   cnt_nxt;
  logic                 rd_vld_r;
  logic                 done_r;
  logic                 done_nxt;
  logic                 sel_b_r;
  logic                 sel_b_nxt;
  logic [WORD_W-1:0]    rdata_r;
  logic [WORD_W-1:0]    rdata_nxt;
  logic                 bad_r;
  logic                 bad_nxt;

  logic                 accept;
  logic                 is_wr;
  logic                 hit_a;
  logic                 hit_b;
  logic                 hit_start;
  logic                 hit_done;
  logic                 hit_low;
  logic                 hit_high;
  logic                 hit_none;
  logic                 go_mac;
  logic                 go_read;
  logic                 drain_end;
  logic                 clearing;
  logic [IDX_W-1:0]     b_off;
  logic [ELEM_AW-1:0]   addr_a;
  logic [ELEM_AW-1:0]   addr_b;
  logic [ELEM_AW-1:0]   raddr_a;
  logic [ELEM_AW-1:0]   raddr_b;
  logic [ELEM_AW-1:0]   waddr_a;
  logic [ELEM_AW-1:0]   waddr_b;
  logic [WORD_W-1:0]    wdata_vec;
  logic [WORD_W-1:0]    q_a;
  logic [WORD_W-1:0]    q_b;
  logic [ACC_W-1:0]     acc;
  mac_ctl_t             mac_ctl;
  mac_sts_t             mac_sts;

  // Decode of the beat on the input ports.
  assign accept    = start && (state_r == ST_IDLE);
  assign is_wr     = (in_op == OP_WRITE);
  assign hit_a     = (in_reg_index < IDX_B_BASE);
  assign hit_b     = !hit_a && (in_reg_index < IDX_START);
  assign hit_start = (in_reg_index == IDX_START);
  assign hit_done  = (in_reg_index == IDX_DONE);
  assign hit_low   = (in_reg_index == IDX_LOW);
  assign hit_high  = (in_reg_index == IDX_HIGH);
  assign hit_none  = !(hit_a || hit_b || hit_start || hit_done || hit_low || hit_high);
  assign go_mac    = accept && is_wr && hit_start && in_write_data[0];
  assign go_read   = accept && !is_wr && (hit_a || hit_b);
  assign drain_end = !rd_vld_r && !mac_sts.pend;

  assign b_off  = in_reg_index - IDX_B_BASE;
  assign addr_a = in_reg_index[ELEM_AW-1:0];
  assign addr_b = b_off[ELEM_AW-1:0];

  // While running, both vectors are read at the element counter.
  assign raddr_a = (state_r == ST_RUN) ? cnt_r : addr_a;
  assign raddr_b = (state_r == ST_RUN) ? cnt_r : addr_b;

  // After reset the element counter walks both stores and writes zero.
  assign clearing  = (state_r == ST_CLEAR);
  assign waddr_a   = clearing ? cnt_r : addr_a;
  assign waddr_b   = clearing ? cnt_r : addr_b;
  assign wdata_vec = clearing ? '0 : in_write_data;

  dpr_ram #(.WIDTH(WORD_W), .DEPTH(VEC_LEN)) u_vec_a (
    .clk   (clk),
    .we    (clearing || (accept && is_wr && hit_a)),
    .waddr (waddr_a),
    .wdata (wdata_vec),
    .raddr (raddr_a),
    .rdata (q_a)
  );

  dpr_ram #(.WIDTH(WORD_W), .DEPTH(VEC_LEN)) u_vec_b (
    .clk   (clk),
    .we    (clearing || (accept && is_wr && hit_b)),
    .waddr (waddr_b),
    .wdata (wdata_vec),
    .raddr (raddr_b),
    .rdata (q_b)
  );

  assign mac_ctl.clr = go_mac;
  assign mac_ctl.en  = rd_vld_r;

  dpr_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (q_a),
    .op_b  (q_b),
    .sts   (mac_sts),
    .acc   (acc)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (cnt_r == ELEM_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          priority if (go_mac) begin
            state_nxt = ST_RUN;
          end else if (go_read) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_READ:  state_nxt = ST_RESP;
      ST_RUN: begin
        if (cnt_r == ELEM_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_end) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control and response capture.
  always_comb begin
    cnt_nxt   = cnt_r;
    done_nxt  = done_r;
    sel_b_nxt = sel_b_r;
    rdata_nxt = rdata_r;
    bad_nxt   = bad_r;
    unique case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          sel_b_nxt = hit_b;
          bad_nxt   = hit_none;
          rdata_nxt = '0;
          if (!is_wr) begin
            priority if (hit_done) begin
              rdata_nxt = WORD_W'(done_r);
            end else if (hit_low) begin
              rdata_nxt = acc[WORD_W-1:0];
            end else if (hit_high) begin
              rdata_nxt = acc[ACC_W-1:WORD_W];
            end else begin
              rdata_nxt = '0;
            end
          end
        end
      end
      ST_READ: begin
        rdata_nxt = sel_b_r ? q_b : q_a;
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_DRAIN: begin
        if (drain_end) begin
          done_nxt = 1'b1;
        end
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= (state_r == ST_RUN);
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_b_r <= sel_b_nxt;
    rdata_r <= rdata_nxt;
    bad_r   <= bad_nxt;
  end

  // Port outputs.
  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = (state_r == ST_RESP);
  assign out_read_data = rdata_r;
  assign out_bad_index = bad_r;

endmodule
